// File: design/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the projective point transform.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned Q_DEPTH_DEF   = 4;

	localparam int unsigned CW        = 32;   // coordinate and coefficient width
	localparam int unsigned REG_W     = 64;   // widest configuration register
	localparam int unsigned LIM_W     = 31;   // degeneracy threshold width
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned PW        = 2 * CW;   // product width
	localparam int unsigned SW        = PW + 2;   // exact sum width, signed
	localparam int unsigned MW        = SW;       // magnitude width

	localparam logic [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_XX_YX  = 3'd0,
		CFG_TX_XY  = 3'd1,
		CFG_YY_TY  = 3'd2,
		CFG_PX_PY  = 3'd3,
		CFG_W_CONST = 3'd4,
		CFG_DEG_LIM = 3'd5
	} cfg_idx_t;

	// one classified point as handed from front to back
	typedef struct packed {
		logic [MW-1:0] nx_mag;
		logic [MW-1:0] ny_mag;
		logic [MW-1:0] w_mag;
		logic          nx_neg;
		logic          ny_neg;
		logic          degen;
	} ppt_entry_t;

endpackage

// File: design/ppt_in_if.sv
// ----------------------------------------------------------------------------
// ppt_in_if
// Input point channel: valid/ready with x and y coordinates.
// ----------------------------------------------------------------------------
interface ppt_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_in;
	logic signed [31:0] y_in;

	modport source (output valid, output x_in, output y_in, input ready);
	modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

// File: design/ppt_out_if.sv
// ----------------------------------------------------------------------------
// ppt_out_if
// Result channel: valid/ready with transformed point and flags.
// ----------------------------------------------------------------------------
interface ppt_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_out;
	logic signed [31:0] y_out;
	logic               status;
	logic               saturated;

	modport source (output valid, output x_out, output y_out, output status,
		output saturated, input ready);
	modport sink   (input valid, input x_out, input y_out, input status,
		input saturated, output ready);
endinterface

// File: design/ppt_front.sv
// ----------------------------------------------------------------------------
// ppt_front
// Coefficient registers, products, exact sums and degeneracy classification.
// ----------------------------------------------------------------------------
module ppt_front #(
	parameter int unsigned FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppt_pkg::REG_W-1:0]      cfg_wdata,
	ppt_in_if.sink                         pt_in,
	input  logic                           q_full,
	output logic                           q_push,
	output ppt_pkg::ppt_entry_t            q_wdata
);
	import ppt_pkg::*;

	logic [REG_W-1:0] xx_yx_q, tx_xy_q, yy_ty_q, px_py_q;
	logic [CW-1:0]    w_const_q;
	logic [LIM_W-1:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_yx_q   <= REG_W'(64'd65536);
			tx_xy_q   <= '0;
			yy_ty_q   <= REG_W'(64'd65536);
			px_py_q   <= '0;
			w_const_q <= CW'(32'd65536);
			lim_q     <= LIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_XX_YX:   xx_yx_q   <= cfg_wdata;
				CFG_TX_XY:   tx_xy_q   <= cfg_wdata;
				CFG_YY_TY:   yy_ty_q   <= cfg_wdata;
				CFG_PX_PY:   px_py_q   <= cfg_wdata;
				CFG_W_CONST: w_const_q <= cfg_wdata[CW-1:0];
				CFG_DEG_LIM: lim_q     <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	logic signed [CW-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
	assign m00 = signed'(xx_yx_q[CW-1:0]);
	assign m10 = signed'(xx_yx_q[REG_W-1:CW]);
	assign m20 = signed'(tx_xy_q[CW-1:0]);
	assign m01 = signed'(tx_xy_q[REG_W-1:CW]);
	assign m11 = signed'(yy_ty_q[CW-1:0]);
	assign m21 = signed'(yy_ty_q[REG_W-1:CW]);
	assign m02 = signed'(px_py_q[CW-1:0]);
	assign m12 = signed'(px_py_q[REG_W-1:CW]);
	assign m22 = signed'(w_const_q);

	logic en, v1_q, v2_q, v3_q;
	assign en          = !(v3_q && q_full);
	assign pt_in.ready = en;

	// stage 1: six products
	logic signed [PW-1:0] px0_s1, py0_s1, px1_s1, py1_s1, pxw_s1, pyw_s1;
	// stage 2: exact sums
	logic signed [SW-1:0] nx_s2, ny_s2, w_s2;
	// stage 3: magnitudes and class
	ppt_entry_t ent_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (en) begin
			v1_q <= pt_in.valid;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	logic signed [SW-1:0] c20, c21, c22;
	assign c20 = SW'(m20) <<< FRAC_BITS;
	assign c21 = SW'(m21) <<< FRAC_BITS;
	assign c22 = SW'(m22) <<< FRAC_BITS;

	logic [MW-1:0] w_mag, lim_sc;
	assign w_mag  = w_s2[SW-1] ? MW'(-w_s2) : MW'(w_s2);
	assign lim_sc = MW'(lim_q) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			px0_s1 <= pt_in.x_in * m00;
			py0_s1 <= pt_in.y_in * m10;
			px1_s1 <= pt_in.x_in * m01;
			py1_s1 <= pt_in.y_in * m11;
			pxw_s1 <= pt_in.x_in * m02;
			pyw_s1 <= pt_in.y_in * m12;

			nx_s2 <= SW'(px0_s1) + SW'(py0_s1) + c20;
			ny_s2 <= SW'(px1_s1) + SW'(py1_s1) + c21;
			w_s2  <= SW'(pxw_s1) + SW'(pyw_s1) + c22;

			ent_s3.nx_mag <= nx_s2[SW-1] ? MW'(-nx_s2) : MW'(nx_s2);
			ent_s3.ny_mag <= ny_s2[SW-1] ? MW'(-ny_s2) : MW'(ny_s2);
			ent_s3.w_mag  <= w_mag;
			ent_s3.nx_neg <= nx_s2[SW-1] != w_s2[SW-1];
			ent_s3.ny_neg <= ny_s2[SW-1] != w_s2[SW-1];
			ent_s3.degen  <= w_mag <= lim_sc;
		end
	end

	assign q_push  = v3_q && !q_full;
	assign q_wdata = ent_s3;

endmodule

// File: design/ppt_queue.sv
// ----------------------------------------------------------------------------
// ppt_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module ppt_queue #(
	parameter int unsigned DEPTH = ppt_pkg::Q_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ppt_pkg::ppt_entry_t wdata,
	input  logic                pop,
	output ppt_pkg::ppt_entry_t rdata,
	output logic                full,
	output logic                empty
);
	import ppt_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(DEPTH + 1);

	ppt_entry_t      ent_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;

	assign full  = cnt_q == CNTW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not follow push");

endmodule

// File: design/ppt_back.sv
// ----------------------------------------------------------------------------
// ppt_back
// Pipelined restoring divider, one quotient bit per stage, and result register.
// ----------------------------------------------------------------------------
module ppt_back #(
	parameter int unsigned FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  ppt_pkg::ppt_entry_t q_rdata,
	output logic                q_pop,
	ppt_out_if.source           pt_out
);
	import ppt_pkg::*;

	localparam int unsigned QB = CW;          // quotient bits kept
	localparam int unsigned RW = MW + QB + 1; // holds divisor shifted by QB

	typedef struct packed {
		logic [RW-1:0] r;
		logic [QB-1:0] q;
		logic          neg;
		logic          ovf;
	} lane_t;

	typedef struct packed {
		lane_t         lx;
		lane_t         ly;
		logic [RW-1:0] d;
		logic          degen;
	} stage_t;

	typedef struct packed {
		logic [CW-1:0] val;
		logic          sat;
	} res_t;

	function automatic lane_t div_step(lane_t l, logic [RW-1:0] d, logic [4:0] sh);
		logic [RW-1:0] ds;
		lane_t         o;
		o  = l;
		ds = d << sh;
		if (l.r >= ds) begin
			o.r     = l.r - ds;
			o.q[sh] = 1'b1;
		end
		return o;
	endfunction

	function automatic res_t finish(lane_t l);
		res_t o;
		o.sat = l.ovf || (l.neg ? (l.q > Q_MIN) : l.q[QB-1]);
		if (o.sat)
			o.val = l.neg ? Q_MIN : Q_MAX;
		else
			o.val = l.neg ? CW'(-l.q) : l.q;
		return o;
	endfunction

	function automatic lane_t load(logic [MW-1:0] mag, logic neg, logic [RW-1:0] d);
		lane_t o;
		o.r   = RW'(mag) << FRAC_BITS;
		o.q   = '0;
		o.neg = neg;
		o.ovf = o.r >= (d << QB);
		return o;
	endfunction

	logic          en_b;
	logic          vld_q [QB+1];
	stage_t        st_s  [QB+1];
	logic          out_vld_q;
	logic [CW-1:0] x_out_q, y_out_q;
	logic          status_q, sat_q;
	logic [RW-1:0] d_in;

	assign en_b  = !out_vld_q || pt_out.ready;
	assign q_pop = en_b && !q_empty;
	assign d_in  = RW'(q_rdata.w_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q[0] <= 1'b0;
		else if (en_b)
			vld_q[0] <= !q_empty;
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			st_s[0].lx    <= load(q_rdata.nx_mag, q_rdata.nx_neg, d_in);
			st_s[0].ly    <= load(q_rdata.ny_mag, q_rdata.ny_neg, d_in);
			st_s[0].d     <= d_in;
			st_s[0].degen <= q_rdata.degen;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam logic [4:0] SH = 5'(QB - 1 - k);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[k+1] <= 1'b0;
			else if (en_b)
				vld_q[k+1] <= vld_q[k];
		end
		always_ff @(posedge clk) begin
			if (en_b) begin
				st_s[k+1].lx    <= div_step(st_s[k].lx, st_s[k].d, SH);
				st_s[k+1].ly    <= div_step(st_s[k].ly, st_s[k].d, SH);
				st_s[k+1].d     <= st_s[k].d;
				st_s[k+1].degen <= st_s[k].degen;
			end
		end
	end

	res_t rx, ry;
	assign rx = finish(st_s[QB].lx);
	assign ry = finish(st_s[QB].ly);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en_b)
			out_vld_q <= vld_q[QB];
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			if (st_s[QB].degen) begin
				x_out_q  <= Q_MAX;
				y_out_q  <= Q_MAX;
				status_q <= 1'b1;
				sat_q    <= 1'b0;
			end else begin
				x_out_q  <= rx.val;
				y_out_q  <= ry.val;
				status_q <= 1'b0;
				sat_q    <= rx.sat || ry.sat;
			end
		end
	end

	assign pt_out.valid     = out_vld_q;
	assign pt_out.x_out     = signed'(x_out_q);
	assign pt_out.y_out     = signed'(y_out_q);
	assign pt_out.status    = status_q;
	assign pt_out.saturated = sat_q;

endmodule

// File: design/projective_point_transform.sv
// ----------------------------------------------------------------------------
// projective_point_transform
// Homography point transform of one Q16.16 point through a 3x3 matrix.
// ----------------------------------------------------------------------------
// Takes one point per transfer and returns one result per transfer, one point
// per clock sustained while the result side is not held. The front computes
// the six 32x32 products (one stage), the exact 66-bit sums for both
// numerators and w (one stage), then magnitudes and the degeneracy test
// |w| <= limit (one stage), and pushes the classified point into a short
// queue. The back pops it into a restoring divider with one quotient bit per
// stage (32 stages plus a load stage that also checks for quotient overflow),
// then a result register. With no stalls the result follows the input
// through the two more front stages, the queue, the 33 divider stages and
// the result register. The queue lets the front keep taking points while the
// result side is held, until the queue is full. The user must write
// coefficients through the config port only while no point is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module projective_point_transform #(
	parameter int unsigned FRAC_BITS = ppt_pkg::FRAC_BITS_DEF,
	parameter int unsigned Q_DEPTH   = ppt_pkg::Q_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppt_pkg::REG_W-1:0]     cfg_wdata,
	ppt_in_if.sink                        pt_in,
	ppt_out_if.source                     pt_out
);
	import ppt_pkg::*;

	// front to queue
	logic       q_push, q_full;
	ppt_entry_t q_wdata;
	// queue to back
	logic       q_pop, q_empty;
	ppt_entry_t q_rdata;

	// front: coefficient registers, multiply, sum, classify
	ppt_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pt_in     (pt_in),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	// decoupling queue
	ppt_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: divider pipeline and result register
	ppt_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.pt_out  (pt_out)
	);

endmodule
